[design/wbps_pkg.sv]
// Package: widths, codes, shared types and helpers for the wildcard byte scan.
package wbps_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int PAT_IDX_W   = 6;
    localparam int LEN_W       = 7;
    localparam int OFFSET_BITS = 32;
    localparam int BASE_W      = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 1;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    // Item opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_BASE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

    // Per-cycle control fanned out to every cell
    typedef struct packed {
        logic load;
        logic step;
        logic clear;
    } cell_ctl_t;

    // Shared byte bus seen by every cell
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] pattern_value;
        logic       pattern_care;
    } cell_bus_t;

    // Index of the last active pattern position: length clamped to 1..MAX_PATTERN, minus one.
    function automatic logic [PAT_IDX_W-1:0] last_position(input logic [LEN_W-1:0] len);
        logic [PAT_IDX_W-1:0] pos;
        if (len == '0) begin
            pos = '0;
        end
        else if (len > LEN_W'(MAX_PATTERN)) begin
            pos = PAT_IDX_W'(MAX_PATTERN - 1);
        end
        else begin
            pos = PAT_IDX_W'(len - LEN_W'(1));
        end
        return pos;
    endfunction

endpackage

[design/wbps_ifs.sv]
// Interfaces: scan item channel and report item channel.
interface wbps_scan_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic [wbps_pkg::PAT_IDX_W-1:0]      pattern_index;
    logic [7:0]                          pattern_value;
    logic                                pattern_care;
    logic [7:0]                          data_byte;
    logic                                last_byte;

    modport source (
        output valid, opcode, pattern_index, pattern_value, pattern_care, data_byte,
               last_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, pattern_index, pattern_value, pattern_care, data_byte,
               last_byte,
        output ready
    );
endinterface

interface wbps_report_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [wbps_pkg::OFFSET_BITS-1:0]    match_offset;
    logic [wbps_pkg::BASE_W-1:0]         match_address;

    modport source (
        output valid, found, match_offset, match_address,
        input  ready
    );
    modport sink (
        input  valid, found, match_offset, match_address,
        output ready
    );
endinterface

[design/wbps_cell.sv]
// Cell: one pattern position with its byte, care bit and partial-match bit.
module wbps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  wbps_pkg::cell_ctl_t ctl,
    input  wbps_pkg::cell_bus_t bus,
    input  logic                prev_partial,
    output logic                partial,
    output logic                hit
);

    logic [7:0] pat_reg;
    logic       care_reg;
    logic       partial_reg;
    logic       partial_next;

    // Pattern storage: written only by a load, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pat_reg  <= bus.pattern_value;
            care_reg <= bus.pattern_care;
        end
    end

    // Extend the neighbor's partial match by this position
    assign hit = prev_partial && (!care_reg || (pat_reg == bus.data_byte));

    always_comb
    begin
        partial_next = partial_reg;
        if (ctl.clear)
        begin
            partial_next = 1'b0;
        end
        else if (ctl.step)
        begin
            partial_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
        end
    end

    assign partial = partial_reg;

endmodule

[design/wildcard_byte_pattern_scan_core.sv]
// Top level: wildcard byte pattern scanner built from a chain of match cells.
//
//  Port        | Dir  | Carries                                          | Handshake
//  ------------+------+--------------------------------------------------+-------------
//  scan        | in   | opcode, pattern_index/value/care, data_byte, last | valid/ready
//  report      | out  | found, match_offset, match_address               | valid/ready
//  cfg_*       | in   | cfg_index, cfg_data (module_base, pattern_length) | cfg_wr_en
//
//  One item is accepted per cycle while scan.ready is high; a data byte updates every
//  active cell at once and moves each partial match one cell along the chain.
//  The report item is registered and is valid the cycle after the last byte.
//  Hold scan.ready low only while a report waits and report.ready is low.
//  Reset clears partial matches, counter, found state and the report slot;
//  pattern bytes are not reset and hold whatever was last loaded.
module wildcard_byte_pattern_scan_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    wbps_scan_if.sink                            scan,
    wbps_report_if.source                        report,
    input  logic                                 cfg_wr_en,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int NC = wbps_pkg::MAX_PATTERN;

    // Configuration registers
    logic [wbps_pkg::BASE_W-1:0]      base_reg;
    logic [wbps_pkg::BASE_W-1:0]      base_next;
    logic [wbps_pkg::LEN_W-1:0]       len_reg;
    logic [wbps_pkg::LEN_W-1:0]       len_next;

    // Scan state
    logic [wbps_pkg::OFFSET_BITS-1:0] count_reg;
    logic [wbps_pkg::OFFSET_BITS-1:0] count_next;
    logic                             found_reg;
    logic                             found_next;
    logic [wbps_pkg::OFFSET_BITS-1:0] off_reg;
    logic [wbps_pkg::OFFSET_BITS-1:0] off_next;

    // Report slot
    logic                             rpt_vld_reg;
    logic                             rpt_vld_next;
    logic                             rpt_found_reg;
    logic                             rpt_found_next;
    logic [wbps_pkg::OFFSET_BITS-1:0] rpt_off_reg;
    logic [wbps_pkg::OFFSET_BITS-1:0] rpt_off_next;

    logic                             accept;
    logic                             load_acc;
    logic                             data_acc;
    logic                             start_acc;
    logic                             step;
    logic                             scan_clear;
    logic                             hit_sel;
    logic                             first_hit;
    logic [wbps_pkg::PAT_IDX_W-1:0]   last_pos;
    logic [wbps_pkg::OFFSET_BITS-1:0] start_off;

    wbps_pkg::cell_bus_t              bus;
    wbps_pkg::cell_ctl_t              ctl [NC];
    logic [NC-1:0]                    partial;
    logic [NC-1:0]                    hit;
    logic [NC-1:0]                    prev_partial;

    // ---------------- Configuration ----------------
    always_comb
    begin
        base_next = base_reg;
        len_next  = len_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wbps_pkg::CFG_MODULE_BASE:    base_next = cfg_data;
                wbps_pkg::CFG_PATTERN_LENGTH: len_next  = cfg_data[wbps_pkg::LEN_W-1:0];
                default:                      ;
            endcase
        end
    end

    // ---------------- Item decode ----------------
    // Accept whenever the report slot is free or is being drained this cycle.
    assign scan.ready = !rpt_vld_reg || report.ready;
    assign accept     = scan.valid && scan.ready;
    assign start_acc  = accept && (scan.opcode == wbps_pkg::OP_START);
    assign load_acc   = accept && (scan.opcode == wbps_pkg::OP_LOAD);
    assign data_acc   = accept && (scan.opcode == wbps_pkg::OP_DATA);

    // Bytes arriving once the counter has saturated take no part in matching
    assign step       = data_acc && (count_reg != wbps_pkg::COUNT_MAX);
    // End of image clears the scan state right after the report is captured
    assign scan_clear = start_acc || (data_acc && scan.last_byte);

    assign last_pos   = wbps_pkg::last_position(len_reg);

    assign bus.data_byte     = scan.data_byte;
    assign bus.pattern_value = scan.pattern_value;
    assign bus.pattern_care  = scan.pattern_care;

    // ---------------- Cell chain ----------------
    // Cell 0 always starts a fresh candidate; each cell extends its left neighbor.
    // Cells beyond the active length do not step; a clear still resets them.
    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign prev_partial[k] = 1'b1;
        end
        else
        begin : g_link
            assign prev_partial[k] = partial[k-1];
        end

        assign ctl[k].load  = load_acc && (scan.pattern_index == wbps_pkg::PAT_IDX_W'(k));
        assign ctl[k].step  = step && (wbps_pkg::PAT_IDX_W'(k) <= last_pos);
        assign ctl[k].clear = scan_clear;

        wbps_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl[k]),
            .bus          (bus),
            .prev_partial (prev_partial[k]),
            .partial      (partial[k]),
            .hit          (hit[k])
        );
    end

    // ---------------- Match tracking ----------------
    assign hit_sel   = hit[last_pos];
    assign first_hit = step && hit_sel && !found_reg;
    // Candidate start offset: current byte position minus the last active index
    assign start_off = count_reg - wbps_pkg::OFFSET_BITS'(last_pos);

    always_comb
    begin
        found_next = found_reg || first_hit;
        off_next   = first_hit ? start_off : off_reg;
        count_next = step ? (count_reg + wbps_pkg::OFFSET_BITS'(1)) : count_reg;

        // Capture the report on the final byte; drop it once taken
        rpt_vld_next   = rpt_vld_reg && !report.ready;
        rpt_found_next = rpt_found_reg;
        rpt_off_next   = rpt_off_reg;
        if (data_acc && scan.last_byte)
        begin
            rpt_vld_next   = 1'b1;
            rpt_found_next = found_next;
            rpt_off_next   = found_next ? off_next : '0;
        end

        if (scan_clear)
        begin
            found_next = 1'b0;
            off_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            len_reg       <= wbps_pkg::LEN_W'(1);
            count_reg     <= '0;
            found_reg     <= 1'b0;
            off_reg       <= '0;
            rpt_vld_reg   <= 1'b0;
            rpt_found_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            off_reg       <= off_next;
            rpt_vld_reg   <= rpt_vld_next;
            rpt_found_reg <= rpt_found_next;
        end
    end

    // Report offset is payload only
    always_ff @(posedge clk)
    begin
        rpt_off_reg <= rpt_off_next;
    end

    // ---------------- Report port ----------------
    // match_address is formed from the registered offset and module_base here
    assign report.valid         = rpt_vld_reg;
    assign report.found         = rpt_found_reg;
    assign report.match_offset  = rpt_off_reg;
    assign report.match_address = rpt_found_reg
                                ? (base_reg + wbps_pkg::BASE_W'(rpt_off_reg)) : '0;

endmodule

[tb/tb_wildcard_byte_pattern_scan_core.sv]
// Testbench for the wildcard byte pattern scanner: directed and random scans.
module tb_wildcard_byte_pattern_scan_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1000;
    localparam int SETTLE_CYCLES = 4;     // report is registered; margin after the last owed report
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;  // cycles with no traffic before giving up

    // One scan item as the block sees it
    typedef struct packed {
        logic [1:0]                     opcode;
        logic [wbps_pkg::PAT_IDX_W-1:0] pattern_index;
        logic [7:0]                     pattern_value;
        logic                           pattern_care;
        logic [7:0]                     data_byte;
        logic                           last_byte;
    } scan_item_t;

    // One search report
    typedef struct packed {
        logic                             found;
        logic [wbps_pkg::OFFSET_BITS-1:0] match_offset;
        logic [wbps_pkg::BASE_W-1:0]      match_address;
    } report_t;

    // Shift-and search predictor plus the queue of reports it still owes.
    class scan_scoreboard;
        logic [wbps_pkg::BASE_W-1:0]      base_addr;
        logic [wbps_pkg::LEN_W-1:0]       len_reg;
        logic [7:0]                       pat_byte [wbps_pkg::MAX_PATTERN];
        logic                             pat_care [wbps_pkg::MAX_PATTERN];
        logic [wbps_pkg::MAX_PATTERN-1:0] partial;
        logic [wbps_pkg::OFFSET_BITS-1:0] byte_count;
        logic                             found_q;
        logic [wbps_pkg::OFFSET_BITS-1:0] first_off;
        report_t                          reports_due [$];
        int                               mismatches;

        function new();
            base_addr  = '0;
            len_reg    = wbps_pkg::LEN_W'(1);
            mismatches = 0;
            foreach (pat_byte[k])
            begin
                pat_byte[k] = '0;
                pat_care[k] = 1'b0;
            end
            clear_scan();
        endfunction

        function void clear_scan();
            partial    = '0;
            byte_count = '0;
            found_q    = 1'b0;
            first_off  = '0;
        endfunction

        function int active_len();
            if (len_reg == '0)
                return 1;
            if (len_reg > wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN))
                return wbps_pkg::MAX_PATTERN;
            return int'(len_reg);
        endfunction

        function logic position_hits(input int k, input logic [7:0] b);
            return !pat_care[k] || (pat_byte[k] == b);
        endfunction

        function void write_register(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [wbps_pkg::CFG_DATA_W-1:0] data);
            if (idx == wbps_pkg::CFG_MODULE_BASE)
                base_addr = data[wbps_pkg::BASE_W-1:0];
            else
                len_reg = data[wbps_pkg::LEN_W-1:0];
        endfunction

        // Advance the search by one accepted item; queue a report on the last byte.
        function void note_item(input scan_item_t it);
            int      n;
            report_t rep;
            case (it.opcode)
                wbps_pkg::OP_START: clear_scan();
                wbps_pkg::OP_LOAD:
                begin
                    pat_byte[it.pattern_index] = it.pattern_value;
                    pat_care[it.pattern_index] = it.pattern_care;
                end
                wbps_pkg::OP_DATA:
                begin
                    if (byte_count != wbps_pkg::COUNT_MAX)
                    begin
                        n = active_len();
                        for (int k = n - 1; k > 0; k--)
                            partial[k] = partial[k-1] && position_hits(k, it.data_byte);
                        partial[0] = position_hits(0, it.data_byte);
                        if (partial[n-1] && !found_q)
                        begin
                            found_q   = 1'b1;
                            first_off = byte_count - wbps_pkg::OFFSET_BITS'(n - 1);
                        end
                        byte_count++;
                    end
                    if (it.last_byte)
                    begin
                        rep.found         = found_q;
                        rep.match_offset  = found_q ? first_off : '0;
                        rep.match_address = found_q
                                          ? base_addr + wbps_pkg::BASE_W'(first_off) : '0;
                        reports_due = {reports_due, rep};
                        clear_scan();
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_report(input report_t got);
            report_t want;
            if (reports_due.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, actual found=%0d offset=%0h",
                         $time, got.found, got.match_offset);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, want.found, got.found);
                mismatches++;
            end
            if (got.match_offset !== want.match_offset)
            begin
                $display("%0t: match_offset mismatch, expected %0h, actual %0h",
                         $time, want.match_offset, got.match_offset);
                mismatches++;
            end
            if (got.match_address !== want.match_address)
            begin
                $display("%0t: match_address mismatch, expected %0h, actual %0h",
                         $time, want.match_address, got.match_address);
                mismatches++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data;

    wbps_scan_if   scan_ch ();
    wbps_report_if report_ch ();

    wildcard_byte_pattern_scan_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan      (scan_ch),
        .report    (report_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    scan_scoreboard sb;

    // Idle rates, changed per phase by the stimulus
    int   tx_idle_pct = 24;
    int   rx_idle_pct = 24;
    logic rx_hold     = 1'b0;
    event rx_hold_start;
    int   items_sent  = 0;

    // What the testbench has loaded, so it can plant matches and never
    // let the block read a pattern position that was never written.
    logic [7:0] shadow_val [wbps_pkg::MAX_PATTERN];
    logic       shadow_care [wbps_pkg::MAX_PATTERN];
    bit         shadow_set [wbps_pkg::MAX_PATTERN];

    always #6 clk = ~clk;

    // Receiver: random back-pressure, or a solid hold-off while rx_hold is up.
    initial
    begin
        report_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            report_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Count the hold-off here so the sender keeps offering items meanwhile.
    initial
    begin
        forever
        begin
            @(rx_hold_start);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    // Sample both channels at the edge where the handshake completes.
    always @(posedge clk)
    begin : sample
        scan_item_t seen;
        report_t    got;
        if (rst_n && scan_ch.valid && scan_ch.ready)
        begin
            seen.opcode        = scan_ch.opcode;
            seen.pattern_index = scan_ch.pattern_index;
            seen.pattern_value = scan_ch.pattern_value;
            seen.pattern_care  = scan_ch.pattern_care;
            seen.data_byte     = scan_ch.data_byte;
            seen.last_byte     = scan_ch.last_byte;
            sb.note_item(seen);
        end
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            got.found         = report_ch.found;
            got.match_offset  = report_ch.match_offset;
            got.match_address = report_ch.match_address;
            sb.check_report(got);
        end
    end

    // Give up when nothing moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((scan_ch.valid && scan_ch.ready) || (report_ch.valid && report_ch.ready) ||
                cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Random filler for every field; callers overwrite what the opcode uses.
    function automatic scan_item_t blank_item(input logic [1:0] op);
        scan_item_t it;
        it.opcode        = op;
        it.pattern_index = wbps_pkg::PAT_IDX_W'($urandom_range(wbps_pkg::MAX_PATTERN - 1));
        it.pattern_value = 8'($urandom_range(255));
        it.pattern_care  = 1'($urandom_range(1));
        it.data_byte     = 8'($urandom_range(255));
        it.last_byte     = 1'($urandom_range(1));
        return it;
    endfunction

    // Offer one item, with a random gap first; leave valid high on return so
    // back-to-back items need no extra edge.
    task automatic send_item(input scan_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            scan_ch.valid <= 1'b0;
            @(posedge clk);
        end
        scan_ch.valid         <= 1'b1;
        scan_ch.opcode        <= it.opcode;
        scan_ch.pattern_index <= it.pattern_index;
        scan_ch.pattern_value <= it.pattern_value;
        scan_ch.pattern_care  <= it.pattern_care;
        scan_ch.data_byte     <= it.data_byte;
        scan_ch.last_byte     <= it.last_byte;
        @(posedge clk);
        while (!scan_ch.ready)
            @(posedge clk);
        if (it.opcode != wbps_pkg::OP_NONE)
            items_sent++;
    endtask

    task automatic load_position(input int idx, input logic [7:0] v, input logic c);
        scan_item_t it;
        it = blank_item(wbps_pkg::OP_LOAD);
        it.pattern_index = wbps_pkg::PAT_IDX_W'(idx);
        it.pattern_value = v;
        it.pattern_care  = c;
        send_item(it);
        shadow_val[idx]  = v;
        shadow_care[idx] = c;
        shadow_set[idx]  = 1'b1;
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic fin);
        scan_item_t it;
        it = blank_item(wbps_pkg::OP_DATA);
        it.data_byte = b;
        it.last_byte = fin;
        send_item(it);
    endtask

    // Drop valid, wait for every owed report, then let the pipeline go quiet.
    task automatic settle();
        scan_ch.valid <= 1'b0;
        while (sb.reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle, so the predictor takes it at once.
    task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [wbps_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // One image scan: optional start, pattern (re)load, then an image with
    // usually planted matches and a little noise; the image always ends on a last byte.
    task automatic run_scan(input int max_img);
        int         n;
        int         img_len;
        int         spot;
        int         mode;
        int         roll;
        logic [7:0] img [$];
        n = sb.active_len();
        if ($urandom_range(1) == 1)
            send_item(blank_item(wbps_pkg::OP_START));
        if ($urandom_range(99) < 60)
        begin
            for (int k = 0; k < n; k++)
                if (n <= 16 || $urandom_range(3) == 0)
                    load_position(k, 8'($urandom_range(255)), $urandom_range(3) != 0);
        end
        // every active position must hold a loaded value before data arrives
        for (int k = 0; k < n; k++)
            if (!shadow_set[k])
                load_position(k, 8'($urandom_range(255)), $urandom_range(3) != 0);

        img_len = ($urandom_range(4) == 0) ? $urandom_range(1, n) : $urandom_range(1, 2 * n + 8);
        if (img_len > max_img)
            img_len = max_img;
        // narrow alphabets make accidental and overlapping matches likely
        mode = $urandom_range(2);
        for (int k = 0; k < img_len; k++)
        begin
            if (mode == 0)
                img = {img, 8'($urandom_range(255))};
            else if (mode == 1)
                img = {img, 8'($urandom_range(3))};
            else
                img = {img, shadow_val[$urandom_range(n - 1)]};
        end
        if (img_len >= n && $urandom_range(9) < 7)
        begin
            repeat ($urandom_range(1, 2))
            begin
                spot = $urandom_range(img_len - n);
                for (int k = 0; k < n; k++)
                    if (shadow_care[k])
                        img[spot + k] = shadow_val[k];
            end
        end

        for (int k = 0; k < img_len; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                send_item(blank_item(wbps_pkg::OP_NONE));
            else if (roll < 6)
                send_item(blank_item(wbps_pkg::OP_START));  // break the image midway
            else if (roll < 8)
                load_position($urandom_range(wbps_pkg::MAX_PATTERN - 1),
                              8'($urandom_range(255)), 1'($urandom_range(1)));
            feed_byte(img[k], k == img_len - 1);
        end
    endtask

    initial
    begin : stimulus
        int                              phase;
        int                              scans;
        int                              max_img;
        int                              r;
        logic [wbps_pkg::LEN_W-1:0]      len_val;
        logic [wbps_pkg::BASE_W-1:0]     base_val;
        logic [wbps_pkg::CFG_DATA_W-1:0] cfg_word;

        sb = new();
        foreach (shadow_set[k])
        begin
            shadow_set[k]  = 1'b0;
            shadow_val[k]  = '0;
            shadow_care[k] = 1'b0;
        end
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_index             <= wbps_pkg::CFG_MODULE_BASE;
        cfg_data              <= '0;
        scan_ch.valid         <= 1'b0;
        scan_ch.opcode        <= wbps_pkg::OP_START;
        scan_ch.pattern_index <= '0;
        scan_ch.pattern_value <= '0;
        scan_ch.pattern_care  <= 1'b0;
        scan_ch.data_byte     <= '0;
        scan_ch.last_byte     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: three-byte pattern FF ?? 00 with an all-ones base so the
        // reported address wraps past 2^64.
        write_reg(wbps_pkg::CFG_MODULE_BASE, '1);
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, wbps_pkg::CFG_DATA_W'(3));
        load_position(0, 8'hFF, 1'b1);
        load_position(1, 8'h00, 1'b0);
        load_position(2, 8'h00, 1'b1);
        send_item(blank_item(wbps_pkg::OP_NONE));    // ignored opcode
        feed_byte(8'h12, 1'b0);
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'hAB, 1'b0);
        feed_byte(8'h00, 1'b1);              // match at offset 1, address wraps to 0
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'h55, 1'b1);              // image shorter than the pattern
        send_item(blank_item(wbps_pkg::OP_START));
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'h01, 1'b0);
        feed_byte(8'h00, 1'b0);              // first match at offset 0
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'h02, 1'b0);
        feed_byte(8'h00, 1'b0);              // a later match must not move the result
        feed_byte(8'h00, 1'b1);
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'h00, 1'b0);
        send_item(blank_item(wbps_pkg::OP_START));   // start drops the partial match
        feed_byte(8'h00, 1'b1);
        load_position(wbps_pkg::MAX_PATTERN - 1, 8'hFF, 1'b1);

        // Random phases; registers change only between them, with the block drained.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            tx_idle_pct = (phase == 3) ? 0 : 24;
            rx_idle_pct = (phase == 3) ? 0 : 24;
            case (phase)
                0:
                begin
                    len_val  = '0;                     // zero length acts as one
                    base_val = '1;
                end
                1:
                begin
                    len_val  = '1;                     // far above the maximum, clamps
                    base_val = {1'b1, {(wbps_pkg::BASE_W-1){1'b0}}};
                end
                2:
                begin
                    len_val  = wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN);
                    base_val = {$urandom, $urandom};
                end
                3:
                begin
                    len_val  = wbps_pkg::LEN_W'(1);
                    base_val = '0;
                end
                4:
                begin
                    len_val  = wbps_pkg::LEN_W'(2);
                    base_val = {$urandom, $urandom};
                end
                default:
                begin
                    r = $urandom_range(99);
                    if (r < 70)
                        len_val = wbps_pkg::LEN_W'($urandom_range(1, 8));
                    else if (r < 80)
                        len_val = wbps_pkg::LEN_W'($urandom_range(9, wbps_pkg::MAX_PATTERN - 1));
                    else if (r < 88)
                        len_val = wbps_pkg::LEN_W'(wbps_pkg::MAX_PATTERN);
                    else if (r < 92)
                        len_val = '0;
                    else
                        len_val = wbps_pkg::LEN_W'($urandom_range(wbps_pkg::MAX_PATTERN + 1,
                                                                  127));
                    r = $urandom_range(3);
                    if (r == 0)
                        base_val = '0;
                    else if (r == 1)
                        base_val = '1;
                    else
                        base_val = {$urandom, $urandom};
                end
            endcase
            // junk above bit 6 of the length word must not matter
            cfg_word = {$urandom, $urandom};
            cfg_word[wbps_pkg::LEN_W-1:0] = len_val;
            write_reg(wbps_pkg::CFG_PATTERN_LENGTH, cfg_word);
            if (phase < 5 || $urandom_range(1) == 1)
                write_reg(wbps_pkg::CFG_MODULE_BASE, base_val);

            max_img = 1000;
            if (phase == 4)
            begin
                // hold the receiver while short images pile up reports
                -> rx_hold_start;
                scans   = 8;
                max_img = 3;
            end
            else if (phase == 3)
                scans = 30;                            // long stretch with no idling
            else if (sb.active_len() > 32)
                scans = 1;
            else
                scans = $urandom_range(2, 5);
            repeat (scans) run_scan(max_img);
            phase++;
        end

        settle();
        if (sb.mismatches == 0 && sb.reports_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
